### rtl/pyd_pkg.sv
// shared constants, types and functions of the pitch/yaw direction vector pipeline
package pyd_pkg;

    localparam int ANGLE_WIDTH  = 16;
    localparam int FRAC_BITS    = 14;
    localparam int OUT_WIDTH    = 16;
    localparam int TURN_WIDTH   = 32;
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_GAIN  = 652032874;
    localparam int Q_BITS       = TURN_WIDTH - 2;
    localparam int EIGHTH_TURN  = 1 << (TURN_WIDTH - 3);
    localparam int PROD_SHIFT   = 2 * Q_BITS - FRAC_BITS;
    localparam int SIN_SHIFT    = Q_BITS - FRAC_BITS;
    localparam int SAT_LIMIT    = 1 << FRAC_BITS;

    typedef logic signed [TURN_WIDTH-1:0]   cval_t;
    typedef logic signed [2*TURN_WIDTH-1:0] prod_t;
    typedef logic signed [OUT_WIDTH-1:0]    dir_t;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_90,
        QUAD_180,
        QUAD_270
    } quad_t;

    // cordic result of one angle before the quadrant is applied
    typedef struct packed {
        cval_t x;
        cval_t y;
        quad_t quad;
    } pyd_rot_t;

    // arctan(2^-idx) as a fraction of a 2^32 turn
    function automatic cval_t atan_entry(input int idx);
        case (idx)
            0:       return 32'sh20000000;
            1:       return 32'sh12E4051E;
            2:       return 32'sh09FB385B;
            3:       return 32'sh051111D4;
            4:       return 32'sh028B0D43;
            5:       return 32'sh0145D7E1;
            6:       return 32'sh00A2F61E;
            7:       return 32'sh00517C55;
            8:       return 32'sh0028BE53;
            9:       return 32'sh00145F2F;
            10:      return 32'sh000A2F98;
            11:      return 32'sh000517CC;
            12:      return 32'sh00028BE6;
            13:      return 32'sh000145F3;
            14:      return 32'sh0000A2FA;
            15:      return 32'sh0000517D;
            16:      return 32'sh000028BE;
            17:      return 32'sh0000145F;
            18:      return 32'sh00000A30;
            19:      return 32'sh00000518;
            20:      return 32'sh0000028C;
            21:      return 32'sh00000146;
            22:      return 32'sh000000A3;
            23:      return 32'sh00000051;
            24:      return 32'sh00000029;
            25:      return 32'sh00000014;
            26:      return 32'sh0000000A;
            27:      return 32'sh00000005;
            28:      return 32'sh00000003;
            29:      return 32'sh00000001;
            default: return '0;
        endcase
    endfunction

endpackage

### rtl/pyd_cordic.sv
// two-lane pipelined rotation-mode cordic, one register stage per iteration
module pyd_cordic
    import pyd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [ANGLE_WIDTH-1:0] pitch_angle,
    input  logic [ANGLE_WIDTH-1:0] yaw_angle,
    output logic                   out_valid,
    input  logic                   out_ready,
    output pyd_rot_t               pitch_rot,
    output pyd_rot_t               yaw_rot
);

    localparam int LANES = 2;

    logic [ANGLE_WIDTH-1:0] angle_in [LANES];

    cval_t x_reg    [LANES][CORDIC_STEPS];
    cval_t y_reg    [LANES][CORDIC_STEPS];
    cval_t z_reg    [LANES][CORDIC_STEPS];
    quad_t quad_reg [LANES][CORDIC_STEPS];

    cval_t x_next    [LANES][CORDIC_STEPS];
    cval_t y_next    [LANES][CORDIC_STEPS];
    cval_t z_next    [LANES][CORDIC_STEPS];
    quad_t quad_next [LANES][CORDIC_STEPS];

    cval_t x_src    [LANES][CORDIC_STEPS];
    cval_t y_src    [LANES][CORDIC_STEPS];
    cval_t z_src    [LANES][CORDIC_STEPS];
    quad_t quad_src [LANES][CORDIC_STEPS];

    logic [CORDIC_STEPS-1:0] valid_reg;
    logic [CORDIC_STEPS-1:0] valid_src;
    logic [CORDIC_STEPS:0]   stage_ready;

    assign angle_in[0] = pitch_angle;
    assign angle_in[1] = yaw_angle;

    // a stage takes new data when it is empty or its content moves on
    always_comb begin
        stage_ready[CORDIC_STEPS] = out_ready;
        for (int i = CORDIC_STEPS - 1; i >= 0; i--) begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
    end

    assign valid_src = {valid_reg[CORDIC_STEPS-2:0], in_valid};

    // quadrant split with rounding, residual kept within an eighth turn
    always_comb begin
        logic [TURN_WIDTH-1:0] turn;
        for (int l = 0; l < LANES; l++) begin
            turn = (TURN_WIDTH'(angle_in[l]) << (TURN_WIDTH - ANGLE_WIDTH))
                 + TURN_WIDTH'(EIGHTH_TURN);
            x_src[l][0]    = cval_t'(CORDIC_GAIN);
            y_src[l][0]    = '0;
            z_src[l][0]    = cval_t'({2'b00, turn[TURN_WIDTH-3:0]}) - cval_t'(EIGHTH_TURN);
            quad_src[l][0] = quad_t'(turn[TURN_WIDTH-1:TURN_WIDTH-2]);
            for (int i = 1; i < CORDIC_STEPS; i++) begin
                x_src[l][i]    = x_reg[l][i-1];
                y_src[l][i]    = y_reg[l][i-1];
                z_src[l][i]    = z_reg[l][i-1];
                quad_src[l][i] = quad_reg[l][i-1];
            end
        end
    end

    // one micro-rotation per stage, shifts floor towards minus infinity
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                quad_next[l][i] = quad_src[l][i];
                if (!z_src[l][i][TURN_WIDTH-1]) begin
                    x_next[l][i] = x_src[l][i] - (y_src[l][i] >>> i);
                    y_next[l][i] = y_src[l][i] + (x_src[l][i] >>> i);
                    z_next[l][i] = z_src[l][i] - atan_entry(i);
                end else begin
                    x_next[l][i] = x_src[l][i] + (y_src[l][i] >>> i);
                    y_next[l][i] = y_src[l][i] - (x_src[l][i] >>> i);
                    z_next[l][i] = z_src[l][i] + atan_entry(i);
                end
            end
        end
    end

    // stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                if (stage_ready[i]) begin
                    valid_reg[i] <= valid_src[i];
                end
            end
        end
    end

    // stage data
    always_ff @(posedge aclk) begin
        for (int l = 0; l < LANES; l++) begin
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                if (stage_ready[i]) begin
                    x_reg[l][i]    <= x_next[l][i];
                    y_reg[l][i]    <= y_next[l][i];
                    z_reg[l][i]    <= z_next[l][i];
                    quad_reg[l][i] <= quad_next[l][i];
                end
            end
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[CORDIC_STEPS-1];
    assign pitch_rot = '{x: x_reg[0][CORDIC_STEPS-1], y: y_reg[0][CORDIC_STEPS-1],
                         quad: quad_reg[0][CORDIC_STEPS-1]};
    assign yaw_rot   = '{x: x_reg[1][CORDIC_STEPS-1], y: y_reg[1][CORDIC_STEPS-1],
                         quad: quad_reg[1][CORDIC_STEPS-1]};

endmodule

### rtl/pyd_combine.sv
// quadrant rotation and the two cos(pitch) products, two register stages
module pyd_combine
    import pyd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  pyd_rot_t pitch_rot,
    input  pyd_rot_t yaw_rot,
    output logic     out_valid,
    input  logic     out_ready,
    output prod_t    prod_x,
    output prod_t    prod_z,
    output cval_t    neg_sin_pitch
);

    logic  sel_valid_reg;
    logic  mul_valid_reg;
    logic  sel_ready;
    logic  mul_ready;

    cval_t cos_p_reg;
    cval_t sin_y_reg;
    cval_t neg_cos_y_reg;
    cval_t neg_sin_p_reg;
    cval_t neg_sin_p_mul_reg;
    prod_t prod_x_reg;
    prod_t prod_z_reg;

    function automatic cval_t quad_cos(input pyd_rot_t r);
        case (r.quad)
            QUAD_0:   return r.x;
            QUAD_90:  return -r.y;
            QUAD_180: return -r.x;
            QUAD_270: return r.y;
            default:  return r.x;
        endcase
    endfunction

    function automatic cval_t quad_sin(input pyd_rot_t r);
        case (r.quad)
            QUAD_0:   return r.y;
            QUAD_90:  return r.x;
            QUAD_180: return -r.y;
            QUAD_270: return -r.x;
            default:  return r.y;
        endcase
    endfunction

    function automatic cval_t quad_neg_cos(input pyd_rot_t r);
        case (r.quad)
            QUAD_0:   return -r.x;
            QUAD_90:  return r.y;
            QUAD_180: return r.x;
            QUAD_270: return -r.y;
            default:  return -r.x;
        endcase
    endfunction

    function automatic cval_t quad_neg_sin(input pyd_rot_t r);
        case (r.quad)
            QUAD_0:   return -r.y;
            QUAD_90:  return -r.x;
            QUAD_180: return r.y;
            QUAD_270: return r.x;
            default:  return -r.y;
        endcase
    endfunction

    // ready chain over the two stages
    assign mul_ready = !mul_valid_reg || out_ready;
    assign sel_ready = !sel_valid_reg || mul_ready;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_valid_reg <= 1'b0;
            mul_valid_reg <= 1'b0;
        end else begin
            if (sel_ready) begin
                sel_valid_reg <= in_valid;
            end
            if (mul_ready) begin
                mul_valid_reg <= sel_valid_reg;
            end
        end
    end

    // quadrant select, negations folded in ahead of the multipliers
    always_ff @(posedge aclk) begin
        if (sel_ready) begin
            cos_p_reg     <= quad_cos(pitch_rot);
            sin_y_reg     <= quad_sin(yaw_rot);
            neg_cos_y_reg <= quad_neg_cos(yaw_rot);
            neg_sin_p_reg <= quad_neg_sin(pitch_rot);
        end
    end

    // q30 by q30 products
    always_ff @(posedge aclk) begin
        if (mul_ready) begin
            prod_x_reg        <= prod_t'(cos_p_reg) * prod_t'(sin_y_reg);
            prod_z_reg        <= prod_t'(cos_p_reg) * prod_t'(neg_cos_y_reg);
            neg_sin_p_mul_reg <= neg_sin_p_reg;
        end
    end

    assign in_ready      = sel_ready;
    assign out_valid     = mul_valid_reg;
    assign prod_x        = prod_x_reg;
    assign prod_z        = prod_z_reg;
    assign neg_sin_pitch = neg_sin_p_mul_reg;

endmodule

### rtl/pyd_round.sv
// round half up, saturate to +-1.0 and hold the result in the output register
module pyd_round
    import pyd_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  prod_t prod_x,
    input  prod_t prod_z,
    input  cval_t neg_sin_pitch,
    output logic  out_valid,
    input  logic  out_ready,
    output dir_t  dir_x,
    output dir_t  dir_y,
    output dir_t  dir_z
);

    localparam prod_t PROD_HALF = prod_t'(1) <<< (PROD_SHIFT - 1);
    localparam cval_t SIN_HALF  = cval_t'(1) <<< (SIN_SHIFT - 1);

    logic out_valid_reg;
    dir_t dir_x_reg;
    dir_t dir_y_reg;
    dir_t dir_z_reg;

    function automatic dir_t round_prod(input prod_t p);
        prod_t r;
        r = (p + PROD_HALF) >>> PROD_SHIFT;
        if (r > prod_t'(SAT_LIMIT)) begin
            r = prod_t'(SAT_LIMIT);
        end else if (r < -prod_t'(SAT_LIMIT)) begin
            r = -prod_t'(SAT_LIMIT);
        end
        return dir_t'(r);
    endfunction

    function automatic dir_t round_q30(input cval_t v);
        cval_t r;
        r = (v + SIN_HALF) >>> SIN_SHIFT;
        if (r > cval_t'(SAT_LIMIT)) begin
            r = cval_t'(SAT_LIMIT);
        end else if (r < -cval_t'(SAT_LIMIT)) begin
            r = -cval_t'(SAT_LIMIT);
        end
        return dir_t'(r);
    endfunction

    // output register frees as soon as its transfer completes
    assign in_ready = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_ready) begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            dir_x_reg <= round_prod(prod_x);
            dir_y_reg <= round_q30(neg_sin_pitch);
            dir_z_reg <= round_prod(prod_z);
        end
    end

    assign out_valid = out_valid_reg;
    assign dir_x     = dir_x_reg;
    assign dir_y     = dir_y_reg;
    assign dir_z     = dir_z_reg;

endmodule

### rtl/pitch_yaw_direction_vector.sv
// top level: pitch and yaw binary angles to a unit view-direction vector
//
//   channel  dir  handshake          payload
//   s_       in   s_valid/s_ready    s_pitch_angle, s_yaw_angle (16 bit turn)
//   m_       out  m_valid/m_ready    m_dir_x, m_dir_y, m_dir_z (signed q1.14)
//
// one transfer per cycle in each direction while m_ does not stall; data passes 30 cordic
// iteration stages, quadrant select, multiply and the round/saturate output register
// every stage has its own valid bit and takes new data when empty or draining,
// so a stall at m_ only backs up full stages and bubbles are squeezed out
// synchronous active-low reset clears the valid bits only; no state otherwise
module pitch_yaw_direction_vector
    import pyd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [ANGLE_WIDTH-1:0] s_pitch_angle,
    input  logic [ANGLE_WIDTH-1:0] s_yaw_angle,
    output logic                   m_valid,
    input  logic                   m_ready,
    output dir_t                   m_dir_x,
    output dir_t                   m_dir_y,
    output dir_t                   m_dir_z
);

    pyd_rot_t pitch_rot;
    pyd_rot_t yaw_rot;
    logic     rot_valid;
    logic     rot_ready;
    prod_t    prod_x;
    prod_t    prod_z;
    cval_t    neg_sin_pitch;
    logic     prod_valid;
    logic     prod_ready;

    // sine/cosine of both angles
    pyd_cordic u_cordic (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .pitch_angle (s_pitch_angle),
        .yaw_angle   (s_yaw_angle),
        .out_valid   (rot_valid),
        .out_ready   (rot_ready),
        .pitch_rot   (pitch_rot),
        .yaw_rot     (yaw_rot)
    );

    // quadrant and products
    pyd_combine u_combine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (rot_valid),
        .in_ready      (rot_ready),
        .pitch_rot     (pitch_rot),
        .yaw_rot       (yaw_rot),
        .out_valid     (prod_valid),
        .out_ready     (prod_ready),
        .prod_x        (prod_x),
        .prod_z        (prod_z),
        .neg_sin_pitch (neg_sin_pitch)
    );

    // rounding and output register
    pyd_round u_round (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (prod_valid),
        .in_ready      (prod_ready),
        .prod_x        (prod_x),
        .prod_z        (prod_z),
        .neg_sin_pitch (neg_sin_pitch),
        .out_valid     (m_valid),
        .out_ready     (m_ready),
        .dir_x         (m_dir_x),
        .dir_y         (m_dir_y),
        .dir_z         (m_dir_z)
    );

    // the input only stalls when a result is held back at the output
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without an output stall");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // every component stays within +-1.0
    a_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_dir_x <= dir_t'(SAT_LIMIT) && m_dir_x >= -dir_t'(SAT_LIMIT)
                  && m_dir_y <= dir_t'(SAT_LIMIT) && m_dir_y >= -dir_t'(SAT_LIMIT)
                  && m_dir_z <= dir_t'(SAT_LIMIT) && m_dir_z >= -dir_t'(SAT_LIMIT)))
        else $error("direction component outside unit range");

endmodule
